@@ design/hrd_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the repeat detector.
package hrd_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int HASH_WORDS  = 4;
    localparam int STORE_WORDS = MAX_ENTRIES * HASH_WORDS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int ENT_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int WPOS_W      = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;

    localparam int WORD_W      = 64;
    localparam int MODE_W      = 2;
    localparam int STS_W       = 2;
    localparam int COUNT_W     = 9;
    localparam int STEP_W      = 8;
    localparam int OUT_DATA_W  = 40;

    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DETECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STS_W-1:0] STS_STORED  = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STS_W-1:0] STS_REPORT  = 2'd2;
    localparam logic [STS_W-1:0] STS_CLEARED = 2'd3;

    typedef struct packed {
        logic             wr_word;
        logic             clear;
        logic             det_start;
        logic             rd_issue;
        logic             fix_hit;
        logic             fix_next;
        logic             cyc_init;
        logic             cyc_hit;
        logic             cyc_next;
        logic             out_load;
        logic [STS_W-1:0] out_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic n_lt2;
        logic w_last;
        logic eq_now;
        logic fix_last;
        logic cyc_last;
    } dp_stat_t;

endpackage

@@ design/hash_trace_repeat_detector_top.sv @@
// Top level of the hash trace repeat detector.
//
// Input stream: s_tuser selects the item (record word, detect, clear), s_tdata
// carries one 64-bit hash word. Four words make one trace entry; up to 256
// entries are held in a 1024-word store (one write, two registered reads).
// Output stream: one result per record, detect or clear item; an unused
// selector is taken and gives no result.
// Record and clear: result valid the cycle after the item; one item per cycle
// while the output is taken.
// Detect: each compared pair of entries is read word by word on the store's
// two read ports and then checked. For n entries the fixed-point walk takes
// up to n-1 pairs and the repeat search up to n(n-1)/2 pairs, stopping at the
// first hit.
// While the output register is full and m_tready is low, s_tready is low.
// Reset clears the entry count, word position and output valid at once; the
// store itself is not swept, so items are taken from the first cycle after it.
module hash_trace_repeat_detector_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hrd_pkg::WORD_W-1:0]      s_tdata,  // [63:0] hash_word
    input  logic [hrd_pkg::MODE_W-1:0]      s_tuser,  // [1:0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [8:0] entry_count, [9] fixed_found, [17:10] fixed_step, [18] cycle_found,
    // [26:19] rep_start, [34:27] rep_len, [39:35] zero
    output logic [hrd_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [hrd_pkg::STS_W-1:0]       m_tuser   // [1:0] status
);
    import hrd_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    hrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hrd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hash_word (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ design/hrd_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module hrd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/hrd_dp.sv @@
// Datapath: trace store, fill counters, pair indices, word compare and result register.
module hrd_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [hrd_pkg::WORD_W-1:0]  hash_word,
    input  hrd_pkg::ctrl_cmd_t          cmd,
    output hrd_pkg::dp_stat_t           stat,
    output logic [hrd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [hrd_pkg::STS_W-1:0]   m_tuser
);
    import hrd_pkg::*;

    logic [CNT_W-1:0]  entries_reg, entries_next;
    logic [WPOS_W-1:0] wpos_reg, wpos_next;
    logic [ENT_W-1:0]  a_reg, b_reg;
    logic [WPOS_W-1:0] rw_reg;
    logic              eq_reg, cmp_vld_reg;
    logic              fix_found_reg, cyc_found_reg;
    logic [STEP_W-1:0] fix_step_reg, cyc_start_reg, cyc_len_reg;

    logic [STS_W-1:0]   o_sts_reg;
    logic [COUNT_W-1:0] o_cnt_reg;
    logic               o_ff_reg, o_cf_reg;
    logic [STEP_W-1:0]  o_fs_reg, o_cs_reg, o_cl_reg;

    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic [WORD_W-1:0] rd_a, rd_b;
    logic              wpos_last;
    logic              report;

    assign wpos_last = (wpos_reg == WPOS_W'(HASH_WORDS - 1));
    assign waddr     = ADDR_W'(entries_reg) * ADDR_W'(HASH_WORDS) + ADDR_W'(wpos_reg);
    assign raddr_a   = ADDR_W'(a_reg) * ADDR_W'(HASH_WORDS) + ADDR_W'(rw_reg);
    assign raddr_b   = ADDR_W'(b_reg) * ADDR_W'(HASH_WORDS) + ADDR_W'(rw_reg);

    hrd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .aclk    (aclk),
        .we      (cmd.wr_word),
        .waddr   (waddr),
        .wdata   (hash_word),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb begin
        entries_next = entries_reg;
        wpos_next    = wpos_reg;
        if (cmd.clear) begin
            entries_next = '0;
            wpos_next    = '0;
        end else if (cmd.wr_word) begin
            if (wpos_last) begin
                wpos_next    = '0;
                entries_next = entries_reg + CNT_W'(1);
            end else begin
                wpos_next = wpos_reg + WPOS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
            wpos_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            entries_reg <= entries_next;
            wpos_reg    <= wpos_next;
            cmp_vld_reg <= cmd.rd_issue;
        end
    end

    assign stat.full     = (entries_reg == CNT_W'(MAX_ENTRIES));
    assign stat.n_lt2    = (entries_reg < CNT_W'(2));
    assign stat.w_last   = (rw_reg == WPOS_W'(HASH_WORDS - 1));
    assign stat.eq_now   = eq_reg && (rd_a == rd_b);
    assign stat.fix_last = (CNT_W'(b_reg) == entries_reg - CNT_W'(1));
    assign stat.cyc_last = stat.fix_last && (CNT_W'(a_reg) == entries_reg - CNT_W'(2));

    always_ff @(posedge aclk) begin
        if (cmd.det_start || cmd.cyc_init) begin
            a_reg  <= '0;
            b_reg  <= ENT_W'(1);
            rw_reg <= '0;
        end else if (cmd.fix_next) begin
            a_reg  <= b_reg;
            b_reg  <= b_reg + ENT_W'(1);
            rw_reg <= '0;
        end else if (cmd.cyc_next) begin
            rw_reg <= '0;
            if (stat.fix_last) begin
                a_reg <= a_reg + ENT_W'(1);
                b_reg <= a_reg + ENT_W'(2);
            end else begin
                b_reg <= b_reg + ENT_W'(1);
            end
        end else if (cmd.rd_issue) begin
            rw_reg <= rw_reg + WPOS_W'(1);
        end

        if (cmd.rd_issue && rw_reg == '0) begin
            eq_reg <= 1'b1;
        end else if (cmp_vld_reg) begin
            eq_reg <= eq_reg && (rd_a == rd_b);
        end

        if (cmd.det_start) begin
            fix_found_reg <= 1'b0;
            fix_step_reg  <= '0;
            cyc_found_reg <= 1'b0;
            cyc_start_reg <= '0;
            cyc_len_reg   <= '0;
        end else begin
            if (cmd.fix_hit) begin
                fix_found_reg <= 1'b1;
                fix_step_reg  <= STEP_W'(b_reg);
            end
            if (cmd.cyc_hit) begin
                cyc_found_reg <= 1'b1;
                cyc_start_reg <= STEP_W'(a_reg);
                cyc_len_reg   <= STEP_W'(b_reg - a_reg);
            end
        end
    end

    assign report = (cmd.out_kind == STS_REPORT);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_sts_reg <= cmd.out_kind;
            o_cnt_reg <= COUNT_W'(entries_next);
            o_ff_reg  <= report && fix_found_reg;
            o_fs_reg  <= report ? fix_step_reg : '0;
            o_cf_reg  <= report && cyc_found_reg;
            o_cs_reg  <= report ? cyc_start_reg : '0;
            o_cl_reg  <= report ? cyc_len_reg : '0;
        end
    end

    assign m_tuser = o_sts_reg;
    assign m_tdata = {5'b0, o_cl_reg, o_cs_reg, o_cf_reg, o_fs_reg, o_ff_reg, o_cnt_reg};

endmodule

@@ design/hrd_ctrl.sv @@
// Controller: input/output handshake, item decode and pairwise search sequencer.
module hrd_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [hrd_pkg::MODE_W-1:0] mode,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  hrd_pkg::dp_stat_t          stat,
    output hrd_pkg::ctrl_cmd_t         cmd
);
    import hrd_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FIX_RD  = 3'd1;
    localparam logic [2:0] ST_FIX_CHK = 3'd2;
    localparam logic [2:0] ST_CYC_RD  = 3'd3;
    localparam logic [2:0] ST_CYC_CHK = 3'd4;
    localparam logic [2:0] ST_RESP    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (mode)
                        MODE_RECORD: begin
                            cmd.wr_word  = !stat.full;
                            cmd.out_load = 1'b1;
                            cmd.out_kind = stat.full ? STS_FULL : STS_STORED;
                        end
                        MODE_DETECT: begin
                            cmd.det_start = 1'b1;
                            state_next    = stat.n_lt2 ? ST_RESP : ST_FIX_RD;
                        end
                        MODE_CLEAR: begin
                            cmd.clear    = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_kind = STS_CLEARED;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIX_RD: begin
                cmd.rd_issue = 1'b1;
                if (stat.w_last) begin
                    state_next = ST_FIX_CHK;
                end
            end
            ST_FIX_CHK: begin
                if (stat.eq_now) begin
                    cmd.fix_hit  = 1'b1;
                    cmd.cyc_init = 1'b1;
                    state_next   = ST_CYC_RD;
                end else if (stat.fix_last) begin
                    cmd.cyc_init = 1'b1;
                    state_next   = ST_CYC_RD;
                end else begin
                    cmd.fix_next = 1'b1;
                    state_next   = ST_FIX_RD;
                end
            end
            ST_CYC_RD: begin
                cmd.rd_issue = 1'b1;
                if (stat.w_last) begin
                    state_next = ST_CYC_CHK;
                end
            end
            ST_CYC_CHK: begin
                if (stat.eq_now) begin
                    cmd.cyc_hit = 1'b1;
                    state_next  = ST_RESP;
                end else if (stat.cyc_last) begin
                    state_next = ST_RESP;
                end else begin
                    cmd.cyc_next = 1'b1;
                    state_next   = ST_CYC_RD;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = STS_REPORT;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

@@ design/hrd_chk.sv @@
// Port-level checker for the repeat detector, bound to the top level.
module hrd_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hrd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [hrd_pkg::STS_W-1:0]       m_tuser
);
    import hrd_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_take_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item taken while result stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_report_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STS_REPORT |-> m_tdata[39:9] == '0)
        else $error("report fields set outside a report");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STS_CLEARED |-> m_tdata[8:0] == '0)
        else $error("entry count not zero after clear");

endmodule

bind hash_trace_repeat_detector_top hrd_chk u_hrd_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/tb_hash_trace_repeat_detector_top.sv @@
// Self-checking stream testbench for the hash trace repeat detector.
module tb_hash_trace_repeat_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 600;
    localparam int WATCHDOG_LIMIT = 700000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int N_DIR          = 26;

    typedef struct packed {
        logic [STS_W-1:0]   status;
        logic [COUNT_W-1:0] entry_count;
        logic               fixed_found;
        logic [STEP_W-1:0]  fixed_step;
        logic               cycle_found;
        logic [STEP_W-1:0]  rep_start;
        logic [STEP_W-1:0]  rep_len;
    } outcome_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] word;
        logic              typed;
        outcome_t          want;
    } stim_row_t;

    localparam outcome_t REPORT_EMPTY = '{STS_REPORT, 9'd0, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam outcome_t REPORT_ONE   = '{STS_REPORT, 9'd1, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam outcome_t CLEARED_NONE = '{STS_CLEARED, 9'd0, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0};
    localparam outcome_t UNTYPED      = '0;
    localparam logic [WORD_W-1:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [WORD_W-1:0] ALT_5 = 64'h5555_5555_5555_5555;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STS_W-1:0]      m_tuser;

    // predictor state
    logic [WORD_W-1:0] trace_store [STORE_WORDS];
    int                trace_entries = 0;
    int                trace_wpos = 0;

    outcome_t pending_outcomes [$];
    bit       steady = 1'b0;
    int       idle_cycles = 0;
    int       n_errors = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_dropped = 0;
    int       n_fixed_hits = 0;
    int       n_cycle_hits = 0;

    stim_row_t dir_rows [N_DIR] = '{
        '{MODE_DETECT, 64'h0, 1'b1, REPORT_EMPTY},
        '{MODE_UNUSED, ONES,  1'b0, UNTYPED},
        '{MODE_RECORD, ONES,  1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, ALT_A, 1'b0, UNTYPED},
        '{MODE_RECORD, ALT_5, 1'b0, UNTYPED},
        '{MODE_DETECT, 64'h0, 1'b1, REPORT_ONE},
        '{MODE_RECORD, ONES,  1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, ALT_A, 1'b0, UNTYPED},
        '{MODE_RECORD, ALT_5, 1'b0, UNTYPED},
        '{MODE_DETECT, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, ONES,  1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_DETECT, ONES,  1'b0, UNTYPED},
        '{MODE_CLEAR,  ONES,  1'b1, CLEARED_NONE},
        '{MODE_DETECT, 64'h0, 1'b1, REPORT_EMPTY},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, 64'h0, 1'b0, UNTYPED},
        '{MODE_RECORD, 64'h1, 1'b0, UNTYPED},
        '{MODE_DETECT, 64'h0, 1'b0, UNTYPED}
    };

    hash_trace_repeat_detector_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit same_entry(input int a, input int b);
        for (int w = 0; w < HASH_WORDS; w++) begin
            if (trace_store[a*HASH_WORDS + w] != trace_store[b*HASH_WORDS + w]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic outcome_t trace_outcome(input logic [MODE_W-1:0] mode,
                                               input logic [WORD_W-1:0] word,
                                               output bit gives);
        outcome_t o;
        int n;
        o = '0;
        gives = 1'b1;
        n = trace_entries;
        case (mode)
            MODE_RECORD: begin
                if (trace_entries >= MAX_ENTRIES) begin
                    o.status = STS_FULL;
                end else begin
                    trace_store[trace_entries*HASH_WORDS + trace_wpos] = word;
                    trace_wpos++;
                    if (trace_wpos == HASH_WORDS) begin
                        trace_wpos = 0;
                        trace_entries++;
                    end
                    o.status = STS_STORED;
                end
            end
            MODE_DETECT: begin
                o.status = STS_REPORT;
                for (int i = 1; i < n && !o.fixed_found; i++) begin
                    if (same_entry(i, i - 1)) begin
                        o.fixed_found = 1'b1;
                        o.fixed_step  = i[STEP_W-1:0];
                    end
                end
                for (int i = 0; i < n && !o.cycle_found; i++) begin
                    for (int j = i + 1; j < n && !o.cycle_found; j++) begin
                        if (same_entry(i, j)) begin
                            o.cycle_found = 1'b1;
                            o.rep_start   = i[STEP_W-1:0];
                            o.rep_len     = 8'(j - i);
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                trace_entries = 0;
                trace_wpos = 0;
                o.status = STS_CLEARED;
            end
            default: gives = 1'b0;
        endcase
        o.entry_count = trace_entries[COUNT_W-1:0];
        return o;
    endfunction

    // valid is only lowered when a gap follows, so it never toggles within one step
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] word,
                             input bit typed = 1'b0, input outcome_t want = '0);
        outcome_t o;
        bit gives;
        o = trace_outcome(mode, word, gives);
        if (gives) begin
            pending_outcomes.push_back(typed ? want : o);
            n_sent++;
        end
        if (!steady && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 32);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // fill every entry with distinct hashes; the last one repeats entry twin_of
    task automatic fill_store(input int twin_of);
        logic [WORD_W-1:0] words [STORE_WORDS];
        logic [WORD_W-1:0] w_val;
        send_item(MODE_CLEAR, rand_word());
        for (int e = 0; e < MAX_ENTRIES; e++) begin
            for (int w = 0; w < HASH_WORDS; w++) begin
                if (e == MAX_ENTRIES - 1) w_val = words[twin_of*HASH_WORDS + w];
                else w_val = {$urandom, 16'(e), 16'($urandom)};
                words[e*HASH_WORDS + w] = w_val;
                send_item(MODE_RECORD, w_val);
            end
        end
        repeat (3) send_item(MODE_RECORD, rand_word());
        send_item(MODE_DETECT, rand_word());
    endtask

    // one trace: entries drawn from fresh, repeated or one-word-altered hashes
    task automatic run_sequence();
        logic [WORD_W-1:0] words [$];
        logic [WORD_W-1:0] w_val;
        int n_ent;
        int pick;
        int src;
        int mutate;
        if ($urandom_range(99) < 80) send_item(MODE_CLEAR, rand_word());
        n_ent = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(8);
        for (int e = 0; e < n_ent; e++) begin
            pick = $urandom_range(99);
            if (e > 0 && pick < 20) src = e - 1;
            else if (e > 0 && pick < 45) src = $urandom_range(e - 1);
            else src = -1;
            mutate = (src >= 0 && $urandom_range(3) == 0) ? $urandom_range(HASH_WORDS - 1) : -1;
            for (int w = 0; w < HASH_WORDS; w++) begin
                w_val = (src < 0 || w == mutate) ? rand_word() : words[src*HASH_WORDS + w];
                words.push_back(w_val);
                send_item(MODE_RECORD, w_val);
            end
            if ($urandom_range(9) == 0) send_item(MODE_DETECT, rand_word());
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, HASH_WORDS - 1)) send_item(MODE_RECORD, rand_word());
        end
        send_item(MODE_DETECT, rand_word());
    endtask

    task automatic run_stimulus();
        int rand_start;
        int seq;
        for (int r = 0; r < N_DIR; r++) begin
            send_item(dir_rows[r].mode, dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
        end
        fill_store(MAX_ENTRIES - 2);
        rand_start = n_sent;
        seq = 0;
        while (n_sent - rand_start < RANDOM_ITEMS) begin
            steady = (seq >= 15 && seq < 35);
            if ($urandom_range(99) < 75) begin
                run_sequence();
            end else begin
                repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(3)), rand_word());
            end
            seq++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no item waiting: status %0d, data %h", m_tuser, m_tdata);
                n_errors++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("status",       want.status,       m_tuser);
                check_field("entry_count",  want.entry_count,  m_tdata[8:0]);
                check_field("fixed_found",  want.fixed_found,  m_tdata[9]);
                check_field("fixed_step",   want.fixed_step,   m_tdata[17:10]);
                check_field("cycle_found",  want.cycle_found,  m_tdata[18]);
                check_field("rep_start",    want.rep_start,    m_tdata[26:19]);
                check_field("rep_len",      want.rep_len,      m_tdata[34:27]);
                check_field("padding",      0,                 m_tdata[39:35]);
                n_checked++;
                if (want.status == STS_FULL) n_dropped++;
                if (want.fixed_found) n_fixed_hits++;
                if (want.cycle_found) n_cycle_hits++;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            run_stimulus();
            while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        join_any
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
        end else begin
            $display("covered: %0d items, %0d results checked, %0d words dropped on a full trace",
                     n_sent, n_checked, n_dropped);
            $display("covered: %0d reports with a fixed point, %0d with a repeated pair",
                     n_fixed_hits, n_cycle_hits);
            if (n_errors == 0) begin
                $display("status: pass");
            end else begin
                $display("status: fail");
            end
        end
        $finish;
    end

endmodule

@@ files.f @@
design/hrd_pkg.sv
design/hrd_ram.sv
design/hrd_dp.sv
design/hrd_ctrl.sv
design/hash_trace_repeat_detector_top.sv
design/hrd_chk.sv
sim/tb_hash_trace_repeat_detector_top.sv
